// ----- hw/rtl/polyline_rect_hit_test_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the polyline rectangle hit test
// Shorthand for clocked assertions, sampled on clk and cut off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_RECT_HIT_TEST_CORE_ASSERT_SVH
`define POLYLINE_RECT_HIT_TEST_CORE_ASSERT_SVH

// Same-cycle implication.
`define PRTH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prth assertion failed");

// Next-cycle implication.
`define PRTH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prth assertion failed");

`endif

// ----- hw/rtl/prth_pkg.sv -----
// ----------------------------------------------------------------------------
// prth_pkg
// Shared constants, register indexes and sign helpers for the hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package prth_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOP    = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RIGHT  = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOTTOM = 2'd3;

    // Sign of a value: both flags low means zero.
    typedef struct packed {
        logic pos;
        logic neg;
    } sgn_t;

    function automatic sgn_t sgn_mul(input sgn_t a, input sgn_t b);
        sgn_t s;
        s.pos = (a.pos & b.pos) | (a.neg & b.neg);
        s.neg = (a.pos & b.neg) | (a.neg & b.pos);
        return s;
    endfunction

    function automatic sgn_t sgn_flip(input sgn_t a);
        sgn_t s;
        s.pos = a.neg;
        s.neg = a.pos;
        return s;
    endfunction

    function automatic logic sgn_zero(input sgn_t a);
        return ~a.pos & ~a.neg;
    endfunction

    function automatic logic sgn_opposite(input sgn_t a, input sgn_t b);
        return (a.pos & b.neg) | (a.neg & b.pos);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prth_seg_test.sv -----
// ----------------------------------------------------------------------------
// prth_seg_test
// Segment against the four rectangle edges: crossing or collinear touch.
// ----------------------------------------------------------------------------
`default_nettype none

module prth_seg_test #(
    parameter int COORD_WIDTH = prth_pkg::COORD_WIDTH_DEF
) (
    input  wire logic signed [COORD_WIDTH-1:0] prev_x,
    input  wire logic signed [COORD_WIDTH-1:0] prev_y,
    input  wire logic signed [COORD_WIDTH-1:0] cur_x,
    input  wire logic signed [COORD_WIDTH-1:0] cur_y,
    input  wire logic signed [COORD_WIDTH-1:0] rect_left,
    input  wire logic signed [COORD_WIDTH-1:0] rect_top,
    input  wire logic signed [COORD_WIDTH-1:0] rect_right,
    input  wire logic signed [COORD_WIDTH-1:0] rect_bottom,
    output logic                               seg_hit
);

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * COORD_WIDTH + 2;
    localparam int NC = 4;

    // Corner order: left-top, right-top, right-bottom, left-bottom.
    logic signed [COORD_WIDTH-1:0] corner_x [NC];
    logic signed [COORD_WIDTH-1:0] corner_y [NC];

    logic signed [DW-1:0] seg_dx;
    logic signed [DW-1:0] seg_dy;
    logic signed [DW-1:0] cor_dx [NC];
    logic signed [DW-1:0] cor_dy [NC];
    logic signed [PW-1:0] prod_l [NC];
    logic signed [PW-1:0] prod_r [NC];

    prth_pkg::sgn_t orient_c [NC];
    logic           on_seg   [NC];

    // Signs of point offsets against the edge lines.
    function automatic prth_pkg::sgn_t sgn_cmp(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        prth_pkg::sgn_t s;
        s.pos = a > b;
        s.neg = a < b;
        return s;
    endfunction

    function automatic logic in_span(
        input logic signed [COORD_WIDTH-1:0] v,
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        return ((v >= a) | (v >= b)) & ((v <= a) | (v <= b));
    endfunction

    assign corner_x[0] = rect_left;
    assign corner_y[0] = rect_top;
    assign corner_x[1] = rect_right;
    assign corner_y[1] = rect_top;
    assign corner_x[2] = rect_right;
    assign corner_y[2] = rect_bottom;
    assign corner_x[3] = rect_left;
    assign corner_y[3] = rect_bottom;

    assign seg_dx = DW'(cur_x) - DW'(prev_x);
    assign seg_dy = DW'(cur_y) - DW'(prev_y);

    // Orientation of each corner against the segment, one cross product each.
    for (genvar c = 0; c < NC; c++) begin : g_corner
        assign cor_dx[c] = DW'(corner_x[c]) - DW'(prev_x);
        assign cor_dy[c] = DW'(corner_y[c]) - DW'(prev_y);
        assign prod_l[c] = PW'(seg_dx) * PW'(cor_dy[c]);
        assign prod_r[c] = PW'(seg_dy) * PW'(cor_dx[c]);
        assign orient_c[c].pos = prod_l[c] > prod_r[c];
        assign orient_c[c].neg = prod_l[c] < prod_r[c];
        assign on_seg[c] = in_span(corner_x[c], prev_x, cur_x)
                         & in_span(corner_y[c], prev_y, cur_y);
    end

    prth_pkg::sgn_t w_lr;
    prth_pkg::sgn_t w_rl;
    prth_pkg::sgn_t w_bt;
    prth_pkg::sgn_t e_d3 [NC];
    prth_pkg::sgn_t e_d4 [NC];
    logic           e_p1 [NC];
    logic           e_p2 [NC];
    logic           e_hit [NC];

    always_comb
    begin
        w_lr = sgn_cmp(rect_right, rect_left);
        w_rl = sgn_cmp(rect_left, rect_right);
        w_bt = sgn_cmp(rect_bottom, rect_top);

        // Top edge, left-top to right-top.
        e_d3[0] = prth_pkg::sgn_mul(w_lr, sgn_cmp(prev_y, rect_top));
        e_d4[0] = prth_pkg::sgn_mul(w_lr, sgn_cmp(cur_y, rect_top));
        e_p1[0] = (prev_y == rect_top) & in_span(prev_x, rect_left, rect_right);
        e_p2[0] = (cur_y == rect_top) & in_span(cur_x, rect_left, rect_right);

        // Right edge, right-top to right-bottom.
        e_d3[1] = prth_pkg::sgn_flip(prth_pkg::sgn_mul(w_bt, sgn_cmp(prev_x, rect_right)));
        e_d4[1] = prth_pkg::sgn_flip(prth_pkg::sgn_mul(w_bt, sgn_cmp(cur_x, rect_right)));
        e_p1[1] = (prev_x == rect_right) & in_span(prev_y, rect_top, rect_bottom);
        e_p2[1] = (cur_x == rect_right) & in_span(cur_y, rect_top, rect_bottom);

        // Bottom edge, right-bottom to left-bottom.
        e_d3[2] = prth_pkg::sgn_mul(w_rl, sgn_cmp(prev_y, rect_bottom));
        e_d4[2] = prth_pkg::sgn_mul(w_rl, sgn_cmp(cur_y, rect_bottom));
        e_p1[2] = (prev_y == rect_bottom) & in_span(prev_x, rect_left, rect_right);
        e_p2[2] = (cur_y == rect_bottom) & in_span(cur_x, rect_left, rect_right);

        // Left edge, left-bottom to left-top.
        e_d3[3] = prth_pkg::sgn_mul(w_bt, sgn_cmp(prev_x, rect_left));
        e_d4[3] = prth_pkg::sgn_mul(w_bt, sgn_cmp(cur_x, rect_left));
        e_p1[3] = (prev_x == rect_left) & in_span(prev_y, rect_top, rect_bottom);
        e_p2[3] = (cur_x == rect_left) & in_span(cur_y, rect_top, rect_bottom);

        seg_hit = 1'b0;
        for (int e = 0; e < NC; e++) begin
            // Edge e runs from corner e to corner (e+1) mod 4.
            e_hit[e] =
                (prth_pkg::sgn_opposite(orient_c[e], orient_c[(e + 1) % NC])
                    & prth_pkg::sgn_opposite(e_d3[e], e_d4[e]))
                | (prth_pkg::sgn_zero(orient_c[e]) & on_seg[e])
                | (prth_pkg::sgn_zero(orient_c[(e + 1) % NC]) & on_seg[(e + 1) % NC])
                | (prth_pkg::sgn_zero(e_d3[e]) & e_p1[e])
                | (prth_pkg::sgn_zero(e_d4[e]) & e_p2[e]);
            seg_hit = seg_hit | e_hit[e];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/polyline_rect_hit_test_core.sv -----
// ----------------------------------------------------------------------------
// polyline_rect_hit_test_core
// Streams polyline vertices and reports whether the polyline touches a box.
// ----------------------------------------------------------------------------
// Vertices arrive one word per cycle in screen coordinates, marked first and
// last; the block answers with one hit word on each vertex marked last. A
// vertex counts when it lies inside the rectangle, edges included, and a
// segment counts when it properly crosses an edge or touches one through a
// collinear endpoint; all tests are exact integer math. Throughput is one
// vertex per cycle while the input is not stalled: each vertex is captured
// in an input register and tested in one pass (four corner cross products,
// eight parallel multipliers of COORD_WIDTH+1 bits), and the verdict on a
// last vertex is registered in the output register, where the result turns
// valid. The only stall on the input side comes from a last vertex meeting
// a full, stalled output register. Write the rectangle registers only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module polyline_rect_hit_test_core #(
    parameter int COORD_WIDTH = prth_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    // Configuration write port
    input  wire logic                                 cfg_write_en,
    input  wire logic [prth_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]               cfg_data,

    // Vertex input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]        point_x,
    input  wire logic signed [COORD_WIDTH-1:0]        point_y,
    input  wire logic                                 first_point,
    input  wire logic                                 last_point,

    // Result output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      hit
);

    // Rectangle registers
    logic signed [COORD_WIDTH-1:0] rect_left_reg;
    logic signed [COORD_WIDTH-1:0] rect_top_reg;
    logic signed [COORD_WIDTH-1:0] rect_right_reg;
    logic signed [COORD_WIDTH-1:0] rect_bottom_reg;

    // Input stage
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic signed [COORD_WIDTH-1:0] s1_x_reg;
    logic signed [COORD_WIDTH-1:0] s1_y_reg;
    logic                          s1_first_reg;
    logic                          s1_last_reg;

    // Polyline state
    logic signed [COORD_WIDTH-1:0] prev_x_reg;
    logic signed [COORD_WIDTH-1:0] prev_y_reg;
    logic                          have_prev_reg;
    logic                          have_prev_next;
    logic                          hit_so_far_reg;
    logic                          hit_so_far_next;

    // Output stage
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          out_hit_reg;

    logic in_accept;
    logic s1_fire;
    logic pt_inside;
    logic seg_hit;
    logic have_prev_eff;
    logic hit_now;

    // A non-last word never needs the output register, so only a last word
    // waits behind a stalled result.
    assign s1_fire   = s1_valid_reg & (~s1_last_reg | ~out_valid_reg | ~out_stall);
    assign in_stall  = s1_valid_reg & ~s1_fire;
    assign in_accept = in_valid & ~in_stall;

    // Inside test on the current vertex, edges included.
    assign pt_inside = (s1_x_reg >= rect_left_reg) & (s1_x_reg <= rect_right_reg)
                     & (s1_y_reg >= rect_top_reg) & (s1_y_reg <= rect_bottom_reg);

    prth_seg_test #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_seg_test (
        .prev_x      (prev_x_reg),
        .prev_y      (prev_y_reg),
        .cur_x       (s1_x_reg),
        .cur_y       (s1_y_reg),
        .rect_left   (rect_left_reg),
        .rect_top    (rect_top_reg),
        .rect_right  (rect_right_reg),
        .rect_bottom (rect_bottom_reg),
        .seg_hit     (seg_hit)
    );

    always_comb
    begin
        // A first mark drops the previous vertex and the sticky flag.
        have_prev_eff = have_prev_reg & ~s1_first_reg;
        hit_now = (hit_so_far_reg & ~s1_first_reg) | pt_inside | (have_prev_eff & seg_hit);

        have_prev_next  = have_prev_reg;
        hit_so_far_next = hit_so_far_reg;
        if (s1_fire)
        begin
            // A last mark closes the polyline.
            have_prev_next  = ~s1_last_reg;
            hit_so_far_next = hit_now & ~s1_last_reg;
        end

        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        // Hold a stalled result; load a new one when a last word fires.
        out_valid_next = (out_valid_reg & out_stall) | (s1_fire & s1_last_reg);
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_left_reg   <= '0;
            rect_top_reg    <= '0;
            rect_right_reg  <= '0;
            rect_bottom_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                prth_pkg::REG_LEFT:   rect_left_reg   <= cfg_data;
                prth_pkg::REG_TOP:    rect_top_reg    <= cfg_data;
                prth_pkg::REG_RIGHT:  rect_right_reg  <= cfg_data;
                prth_pkg::REG_BOTTOM: rect_bottom_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            have_prev_reg  <= 1'b0;
            hit_so_far_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            have_prev_reg  <= have_prev_next;
            hit_so_far_reg <= hit_so_far_next;
            out_valid_reg  <= out_valid_next;
            if (s1_fire)
            begin
                prev_x_reg <= s1_x_reg;
                prev_y_reg <= s1_y_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_x_reg     <= point_x;
            s1_y_reg     <= point_y;
            s1_first_reg <= first_point;
            s1_last_reg  <= last_point;
        end
        if (s1_fire & s1_last_reg)
        begin
            out_hit_reg <= hit_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = out_hit_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/prth_checker.sv -----
// ----------------------------------------------------------------------------
// prth_checker
// Port-level checks on the hit test core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "polyline_rect_hit_test_core_assert.svh"

module prth_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire logic hit
);

    logic in_acc;

    assign in_acc = in_valid & ~in_stall;

    // Input backs up only behind a result that is held.
    `PRTH_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)

    // A held result keeps its word.
    `PRTH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(hit))

    // With nothing taken and nothing pending, no result appears.
    `PRTH_ASSERT_NEXT(a_no_phantom, (!in_acc && !out_valid) ##1 (!in_acc && !out_valid),
        !out_valid)

endmodule

bind polyline_rect_hit_test_core prth_checker u_prth_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit)
);

`default_nettype wire

// ----- test/tb_polyline_rect_hit_test_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyline_rect_hit_test_core
// Self-checking bench for the streaming polyline/rectangle hit test.
// ----------------------------------------------------------------------------
// Vertices go in through a queue-fed driver. An exact integer model of the
// hit test predicts one hit word per vertex marked last, and a monitor checks
// every result word against it in order. The rectangle is reprogrammed
// between phases while the block is idle: the reset box, normal boxes, the
// full coordinate range, reversed, zero-height and zero-width boxes. Both
// sides idle and stall in random bursts, except in the final phase.
// ----------------------------------------------------------------------------

module tb_polyline_rect_hit_test_core;

    localparam int CW         = prth_pkg::COORD_WIDTH_DEF;
    localparam int CMIN       = -(1 << (CW - 1));
    localparam int CMAX       = (1 << (CW - 1)) - 1;
    localparam int SETTLE_CYC = 8;          // quiet time after the last result word
    localparam int TIMEOUT_NS = 4_000_000;  // far above the slowest run

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 first;
        logic                 last;
    } vertex_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                                 clk          = 1'b0;
    logic                                 rst_n        = 1'b0;
    logic                                 cfg_write_en = 1'b0;
    logic [prth_pkg::CFG_INDEX_WIDTH-1:0] cfg_index    = prth_pkg::REG_LEFT;
    logic [CW-1:0]                        cfg_data     = '0;
    logic                                 in_valid     = 1'b0;
    logic                                 in_stall;
    logic signed [CW-1:0]                 point_x      = '0;
    logic signed [CW-1:0]                 point_y      = '0;
    logic                                 first_point  = 1'b0;
    logic                                 last_point   = 1'b0;
    logic                                 out_valid;
    logic                                 out_stall    = 1'b0;
    logic                                 hit;

    polyline_rect_hit_test_core #(
        .COORD_WIDTH (CW)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .point_x      (point_x),
        .point_y      (point_y),
        .first_point  (first_point),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    vertex_t vertex_backlog[$];   // words waiting for the driver
    bit      pending_hits[$];     // predicted hit words, oldest first

    int  vtx_queued    = 0;
    int  vtx_presented = 0;
    int  vtx_accepted  = 0;
    int  mismatches    = 0;
    int  hits_seen     = 0;
    int  clears_seen   = 0;
    int  box_settings  = 1;       // the reset box counts as one
    int  send_idle     = 0;
    int  recv_stall    = 0;
    bit  calm          = 1'b0;    // no idling on either side when set

    // Model copy of the rectangle registers and the polyline state
    longint box_l = 0, box_t = 0, box_r = 0, box_b = 0;
    longint prev_px = 0, prev_py = 0;
    bit     prev_ok = 1'b0;
    bit     touched = 1'b0;

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        rst_n = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Hit prediction, exact integer geometry
    // ------------------------------------------------------------------------

    // Sign of (b - a) x (c - a)
    function automatic int turn_of(input longint ax, ay, bx, by, cx, cy);
        longint lhs, rhs;
        lhs = (bx - ax) * (cy - ay);
        rhs = (by - ay) * (cx - ax);
        if (lhs > rhs) return 1;
        if (lhs < rhs) return -1;
        return 0;
    endfunction

    // c lies in the bounding box of segment a-b
    function automatic bit on_span(input longint ax, ay, bx, by, cx, cy);
        longint lox, hix, loy, hiy;
        lox = (ax < bx) ? ax : bx;
        hix = (ax < bx) ? bx : ax;
        loy = (ay < by) ? ay : by;
        hiy = (ay < by) ? by : ay;
        return (lox <= cx) && (cx <= hix) && (loy <= cy) && (cy <= hiy);
    endfunction

    // Proper crossing, or an endpoint collinear with and inside the other segment
    function automatic bit segs_meet(input longint p1x, p1y, p2x, p2y,
                                     input longint q1x, q1y, q2x, q2y);
        int d1, d2, d3, d4;
        d1 = turn_of(p1x, p1y, p2x, p2y, q1x, q1y);
        d2 = turn_of(p1x, p1y, p2x, p2y, q2x, q2y);
        d3 = turn_of(q1x, q1y, q2x, q2y, p1x, p1y);
        d4 = turn_of(q1x, q1y, q2x, q2y, p2x, p2y);
        if ((d1 * d2 < 0) && (d3 * d4 < 0)) return 1'b1;
        if (d1 == 0 && on_span(p1x, p1y, p2x, p2y, q1x, q1y)) return 1'b1;
        if (d2 == 0 && on_span(p1x, p1y, p2x, p2y, q2x, q2y)) return 1'b1;
        if (d3 == 0 && on_span(q1x, q1y, q2x, q2y, p1x, p1y)) return 1'b1;
        if (d4 == 0 && on_span(q1x, q1y, q2x, q2y, p2x, p2y)) return 1'b1;
        return 1'b0;
    endfunction

    // Advance the polyline state by one accepted vertex; queue a hit word on last
    function automatic void trace_vertex(input longint x, y, input bit f, l);
        if (f) begin
            prev_ok = 1'b0;
            touched = 1'b0;
        end
        if (x >= box_l && x <= box_r && y >= box_t && y <= box_b)
            touched = 1'b1;
        if (prev_ok) begin
            if (segs_meet(prev_px, prev_py, x, y, box_l, box_t, box_r, box_t) ||
                segs_meet(prev_px, prev_py, x, y, box_r, box_t, box_r, box_b) ||
                segs_meet(prev_px, prev_py, x, y, box_r, box_b, box_l, box_b) ||
                segs_meet(prev_px, prev_py, x, y, box_l, box_b, box_l, box_t))
                touched = 1'b1;
        end
        prev_px = x;
        prev_py = y;
        prev_ok = 1'b1;
        if (l) begin
            pending_hits = {pending_hits, touched};
            prev_ok = 1'b0;
            touched = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Rising edge: mirror register writes, predict on accepted vertices,
    // check accepted result words
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_write_en) begin
                case (cfg_index)
                    prth_pkg::REG_LEFT:   box_l = longint'($signed(cfg_data));
                    prth_pkg::REG_TOP:    box_t = longint'($signed(cfg_data));
                    prth_pkg::REG_RIGHT:  box_r = longint'($signed(cfg_data));
                    prth_pkg::REG_BOTTOM: box_b = longint'($signed(cfg_data));
                    default: ;
                endcase
            end

            if (in_valid && !in_stall) begin
                trace_vertex(longint'(point_x), longint'(point_y), first_point, last_point);
                vtx_accepted++;
            end

            if (out_valid && !out_stall) begin
                if (pending_hits.size() == 0) begin
                    $error("hit word with no prediction waiting: actual %0b", hit);
                    mismatches++;
                end else begin
                    bit want;
                    want = pending_hits.pop_front();
                    if (hit !== want) begin
                        $error("hit mismatch: expected %0b, actual %0b", want, hit);
                        mismatches++;
                    end
                    if (want) hits_seen++;
                    else      clears_seen++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: falling edge, holds a stalled word, idles in random bursts
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (vtx_presented != vtx_accepted) begin
            // word still waiting: hold valid and payload
        end else if (send_idle > 0) begin
            in_valid <= 1'b0;
            send_idle--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            send_idle = $urandom_range(1, 6) - 1;
        end else if (vertex_backlog.size() != 0) begin
            vertex_t v;
            v = vertex_backlog.pop_front();
            point_x     <= v.x;
            point_y     <= v.y;
            first_point <= v.first;
            last_point  <= v.last;
            in_valid    <= 1'b1;
            vtx_presented++;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // Result side back-pressure, also in random bursts
    always @(negedge clk) begin
        if (recv_stall > 0) begin
            out_stall <= 1'b1;
            recv_stall--;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            recv_stall = $urandom_range(1, 6) - 1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_vertex(input int x, y, input bit f, l);
        vertex_t v;
        v.x     = x[CW-1:0];
        v.y     = y[CW-1:0];
        v.first = f;
        v.last  = l;
        vertex_backlog = {vertex_backlog, v};
        vtx_queued++;
    endtask

    // Wait until every word is in and every hit word is out, then let the
    // pipeline run empty before touching the registers
    task automatic settle();
        while (vtx_accepted != vtx_queued || pending_hits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic write_reg(input logic [prth_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input int val);
        @(negedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val[CW-1:0];
        @(negedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_box(input int l, t, r, b);
        write_reg(prth_pkg::REG_LEFT,   l);
        write_reg(prth_pkg::REG_TOP,    t);
        write_reg(prth_pkg::REG_RIGHT,  r);
        write_reg(prth_pkg::REG_BOTTOM, b);
        box_settings++;
    endtask

    function automatic int any_coord();
        return int'($urandom_range(0, CMAX - CMIN)) + CMIN;
    endfunction

    // Coordinate biased toward the box span, its bounds and the range ends
    function automatic int pick_coord(input int lo, hi);
        int a, b, v;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 7))
            0, 1: v = a + int'($urandom_range(0, b - a));
            2:    v = a;
            3:    v = b;
            4:    v = $urandom_range(0, 1) ? a - 1 : b + 1;
            5:    v = any_coord();
            6:    v = $urandom_range(0, 1) ? CMIN : CMAX;
            default: v = a + int'($urandom_range(0, b - a)) + int'($urandom_range(0, 6)) - 3;
        endcase
        if (v < CMIN) v = CMIN;
        if (v > CMAX) v = CMAX;
        return v;
    endfunction

    // Mostly well-formed polylines around the box, with some stray words
    task automatic queue_polylines(input int n_items, input int l, t, r, b);
        int target, len;
        target = vtx_queued + n_items;
        while (vtx_queued < target) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_vertex(pick_coord(l, r), pick_coord(t, b),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++) begin
                    bit f;
                    f = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
                    queue_vertex(pick_coord(l, r), pick_coord(t, b), f, i == len - 1);
                end
            end
        end
    endtask

    // Random box; sorted most of the time, reversed now and then
    task automatic random_box_phase(input int n_items);
        int cx, cy, hw, hh, l, t, r, b;
        cx = any_coord();
        cy = any_coord();
        hw = $urandom_range(0, 3000);
        hh = $urandom_range(0, 3000);
        l  = (cx - hw < CMIN) ? CMIN : cx - hw;
        r  = (cx + hw > CMAX) ? CMAX : cx + hw;
        t  = (cy - hh < CMIN) ? CMIN : cy - hh;
        b  = (cy + hh > CMAX) ? CMAX : cy + hh;
        if ($urandom_range(0, 3) == 0) set_box(r, b, l, t);
        else                           set_box(l, t, r, b);
        queue_polylines(n_items, l, t, r, b);
        settle();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        @(posedge rst_n);
        repeat (2) @(negedge clk);

        // Reset box is the single point at the origin.
        // Start without a first mark, then a segment through the point box.
        queue_vertex(0, 0, 1'b0, 1'b1);
        queue_vertex(-5, 0, 1'b1, 1'b0);
        queue_vertex(5, 0, 1'b0, 1'b1);
        queue_vertex(1, 1, 1'b1, 1'b1);
        settle();

        set_box(-100, -50, 100, 50);
        queue_vertex(0, 0, 1'b1, 1'b1);             // single vertex inside
        queue_vertex(100, 50, 1'b1, 1'b1);          // on a corner
        queue_vertex(101, 50, 1'b1, 1'b1);          // just outside
        queue_vertex(-200, 0, 1'b1, 1'b0);          // proper crossing
        queue_vertex(200, 0, 1'b0, 1'b1);
        queue_vertex(-200, -50, 1'b1, 1'b0);        // on the top line, short of it
        queue_vertex(-150, -50, 1'b0, 1'b1);
        queue_vertex(-300, -50, 1'b0, 1'b0);        // no first mark after a last
        queue_vertex(300, -50, 1'b0, 1'b1);         // overlaps the top side
        queue_vertex(CMIN, CMIN, 1'b1, 1'b0);       // full-range diagonal
        queue_vertex(CMAX, CMAX, 1'b0, 1'b1);
        queue_vertex(CMAX, CMIN, 1'b1, 1'b0);       // loop around the box
        queue_vertex(CMIN, CMIN, 1'b0, 1'b0);
        queue_vertex(CMIN, CMAX, 1'b0, 1'b0);
        queue_vertex(CMAX, CMAX, 1'b0, 1'b1);
        queue_vertex(-200, -200, 1'b1, 1'b0);       // first mark mid-line drops the hit
        queue_vertex(200, 200, 1'b0, 1'b0);
        queue_vertex(500, 500, 1'b1, 1'b0);
        queue_vertex(600, 600, 1'b0, 1'b1);
        queue_vertex(7, 7, 1'b1, 1'b0);             // zero-length segment inside
        queue_vertex(7, 7, 1'b0, 1'b1);
        queue_polylines(180, -100, -50, 100, 50);
        settle();

        set_box(CMIN, CMIN, CMAX, CMAX);
        queue_polylines(140, CMIN, CMIN, CMAX, CMAX);
        settle();

        set_box(100, 50, -100, -50);
        queue_polylines(140, -100, -50, 100, 50);
        settle();

        set_box(-40, 7, 60, 7);                     // zero height
        queue_polylines(140, -40, 7, 60, 7);
        settle();

        set_box(CMAX, CMAX, CMIN, CMIN);            // reversed full range
        queue_polylines(100, CMIN, CMIN, CMAX, CMAX);
        settle();

        set_box(3, -9, 3, 12);                      // zero width
        queue_polylines(100, 3, -9, 3, 12);
        settle();

        random_box_phase(110);
        random_box_phase(110);

        // Final stretch at full rate on both sides
        calm = 1'b1;
        random_box_phase(130);

        $display("Covered %0d vertices, %0d hit words (%0d set, %0d clear), %0d box settings",
                 vtx_accepted, hits_seen + clears_seen, hits_seen, clears_seen, box_settings);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d of %0d vertices in, %0d hit words outstanding",
                 vtx_accepted, vtx_queued, pending_hits.size());
        $display("FAIL");
        $finish;
    end

endmodule
